FILE: rtl/core/gccl_pkg.sv
// Package for the grid connected component labeler.
// Holds item structs, opcodes, register indexes, state types and defaults.
// No dependencies.
package gccl_pkg;

  localparam int MAX_COLS_DEF  = 16;
  localparam int MAX_ROWS_DEF  = 16;
  localparam int TYPE_BITS_DEF = 3;

  localparam int CFG_W = 5;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_LABEL = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic REG_BOARD_WIDTH  = 1'b0;
  localparam logic REG_BOARD_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] col;
    logic [3:0] row;
    logic [2:0] cell_type;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] region_label;
    logic [8:0] region_size;
    logic [8:0] label_total;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_SIZE,
    ST_RD_OUT,
    ST_PASS,
    ST_SCLR,
    ST_CNT_LAB,
    ST_CNT_SIZE,
    ST_CNT_WR
  } state_e;

  typedef enum logic [1:0] {
    PASS_FIRST,
    PASS_FWD,
    PASS_BWD
  } pass_e;

endpackage

FILE: rtl/core/gccl_cell.sv
// One cell of the column line buffer: holds a valid flag, a cell type and a label.
// Depends on nothing beyond its parameters.
module gccl_cell #(
  parameter int TYPE_BITS = 3,
  parameter int LABEL_W   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 shift_i,
  input  logic                 valid_i,
  input  logic [TYPE_BITS-1:0] type_i,
  input  logic [LABEL_W-1:0]   label_i,
  output logic                 valid_o,
  output logic [TYPE_BITS-1:0] type_o,
  output logic [LABEL_W-1:0]   label_o
);

  logic                 valid_q;
  logic [TYPE_BITS-1:0] type_q;
  logic [LABEL_W-1:0]   label_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      type_q  <= type_i;
      label_q <= label_i;
    end
  end

  assign valid_o = valid_q;
  assign type_o  = type_q;
  assign label_o = label_q;

endmodule

FILE: rtl/core/grid_connected_component_labeler_core.sv
// Top level of the grid connected component labeler.
// Uses gccl_pkg and a line of gccl_cell instances as the column buffer.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o, in_item_i) takes one item per
//   operation: write cell type, run labeling, or read label and region size.
// - Output channel (out_valid_o / out_stall_i, out_item_o) returns one item
//   for every input item, in order, through an output register.
// - Configuration channel (cfg_valid_i / cfg_ready_o) sets board width and
//   height; always ready; the user must write it only while the block is idle (no check).
// Operation steps:
// - Write: result registered on acceptance; the block stays idle and takes a
//   new item while the result is held, unless the receiver stalls.
// - Read: label memory read, then size memory read, then the output register.
// - Label run: a first raster pass, then forward/backward min passes until a
//   forward and a backward pass change nothing, a clear of the size memory,
//   and region counting of the w*h cells by size memory read-modify-write.
// Reset: a clearing pass over every cell address zeroes the label and size
// memories; no input item is taken meanwhile.
// A stalled receiver holds the result; one new item can still be accepted
// in the cycle the held result is taken.
module grid_connected_component_labeler_core
  import gccl_pkg::*;
#(
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int TYPE_BITS = TYPE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int NCELLS = MAX_COLS * MAX_ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam int LW     = AW;
  localparam int CW     = $clog2(NCELLS + 1);
  localparam int XW     = $clog2(MAX_COLS);
  localparam int YW     = $clog2(MAX_ROWS);
  localparam int WW     = $clog2(MAX_COLS + 1);
  localparam int HW     = $clog2(MAX_ROWS + 1);

  function automatic logic [AW-1:0] cell_addr(input logic [31:0] x, input logic [31:0] y);
    return AW'(x * MAX_ROWS + y);
  endfunction

  // Configuration registers and their clamped views
  logic [CFG_W-1:0] width_q, height_q;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [XW-1:0]    wm1;
  logic [YW-1:0]    hm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(9);
      height_q <= CFG_W'(9);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BOARD_WIDTH:  width_q  <= cfg_data_i;
        REG_BOARD_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_COLS)) begin
      w_eff = WW'(MAX_COLS);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_ROWS)) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = HW'(height_q);
    end
    wm1 = XW'(w_eff - WW'(1));
    hm1 = YW'(h_eff - HW'(1));
  end

  // Control and datapath registers
  state_e            state_q, state_d;
  pass_e             pass_q, pass_d;
  logic [XW-1:0]     x_q;
  logic [YW-1:0]     y_q;
  logic              issue_q;
  logic              s1_valid_q, s1_inb_q, s1_edge_q;
  logic [AW-1:0]     s1_addr_q;
  logic              prev_valid_q;
  logic [TYPE_BITS-1:0] prev_type_q;
  logic [LW-1:0]     prev_label_q;
  logic [CW-1:0]     next_q, issued_q;
  logic              changed_q;
  logic [AW-1:0]     cnt_q;
  logic [LW-1:0]     lab_hold_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // Memories and their ports
  logic [TYPE_BITS-1:0] type_mem  [NCELLS];
  logic [LW-1:0]        label_mem [NCELLS];
  logic [CW-1:0]        size_mem  [NCELLS];
  logic [TYPE_BITS-1:0] t_rd_q;
  logic [LW-1:0]        l_rd_q;
  logic [CW-1:0]        s_rd_q;
  logic [AW-1:0]        t_raddr, l_raddr, s_raddr, t_waddr, l_waddr, s_waddr;
  logic                 t_we, l_we, s_we;
  logic [TYPE_BITS-1:0] t_wdata;
  logic [LW-1:0]        l_wdata;
  logic [CW-1:0]        s_wdata;

  always_ff @(posedge clk_i) begin
    if (t_we) type_mem[t_waddr] <= t_wdata;
    if (l_we) label_mem[l_waddr] <= l_wdata;
    if (s_we) size_mem[s_waddr] <= s_wdata;
    t_rd_q <= type_mem[t_raddr];
    l_rd_q <= label_mem[l_raddr];
    s_rd_q <= size_mem[s_raddr];
  end

  // Column line buffer: the tail holds the neighbor one column away
  logic                 c_valid [MAX_ROWS];
  logic [TYPE_BITS-1:0] c_type  [MAX_ROWS];
  logic [LW-1:0]        c_label [MAX_ROWS];
  logic                 chain_clr, chain_shift;
  logic                 new_valid;
  logic [LW-1:0]        new_label;

  for (genvar gi = 0; gi < MAX_ROWS; gi++) begin : g_chain
    if (gi == 0) begin : g_head
      gccl_cell #(.TYPE_BITS(TYPE_BITS), .LABEL_W(LW)) u_cell (
        .clk_i, .rst_ni,
        .clr_i(chain_clr), .shift_i(chain_shift),
        .valid_i(new_valid), .type_i(t_rd_q), .label_i(new_label),
        .valid_o(c_valid[gi]), .type_o(c_type[gi]), .label_o(c_label[gi])
      );
    end else begin : g_body
      gccl_cell #(.TYPE_BITS(TYPE_BITS), .LABEL_W(LW)) u_cell (
        .clk_i, .rst_ni,
        .clr_i(chain_clr), .shift_i(chain_shift),
        .valid_i(c_valid[gi-1]), .type_i(c_type[gi-1]), .label_i(c_label[gi-1]),
        .valid_o(c_valid[gi]), .type_o(c_type[gi]), .label_o(c_label[gi])
      );
    end
  end

  // Handshake
  logic accept, out_take, outside;
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign outside     = (32'(in_item_i.col) >= 32'(w_eff)) ||
                       (32'(in_item_i.row) >= 32'(h_eff));

  // Pass sequencing flags
  logic fwd_dir, last_issue, pass_done, start_pass, clr_last, cnt_last;
  logic m_left, m_up, take_new, lab_changed;

  assign fwd_dir    = (pass_q != PASS_BWD);
  assign last_issue = fwd_dir ? (x_q == wm1 && y_q == YW'(MAX_ROWS - 1))
                              : (x_q == '0 && y_q == '0);
  assign pass_done  = (state_q == ST_PASS) && !issue_q && !s1_valid_q;
  assign clr_last   = (cnt_q == AW'(NCELLS - 1));
  assign cnt_last   = (x_q == wm1) && (y_q == hm1);

  // Next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.opcode)
            OP_LABEL: begin
              state_d = ST_PASS;
              pass_d  = PASS_FIRST;
            end
            OP_READ: begin
              if (!outside) state_d = ST_RD_SIZE;
            end
            default: ;
          endcase
        end
      end
      ST_RD_SIZE: state_d = ST_RD_OUT;
      ST_RD_OUT:  state_d = ST_IDLE;
      ST_PASS: begin
        if (pass_done) begin
          unique case (pass_q)
            PASS_FIRST: pass_d = PASS_FWD;
            PASS_FWD:   pass_d = PASS_BWD;
            PASS_BWD: begin
              if (changed_q) pass_d = PASS_FWD;
              else state_d = ST_SCLR;
            end
            default: ;
          endcase
        end
      end
      ST_SCLR: begin
        if (clr_last) state_d = ST_CNT_LAB;
      end
      ST_CNT_LAB:  state_d = ST_CNT_SIZE;
      ST_CNT_SIZE: state_d = ST_CNT_WR;
      ST_CNT_WR: begin
        if (cnt_last) state_d = ST_IDLE;
        else state_d = ST_CNT_LAB;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: memory controls, merge logic, line buffer controls
  always_comb begin
    logic have;
    logic [LW-1:0] cand;
    have = (pass_q != PASS_FIRST);
    cand = l_rd_q;
    m_left = c_valid[MAX_ROWS-1] && (c_type[MAX_ROWS-1] == t_rd_q);
    m_up   = prev_valid_q && !s1_edge_q && (prev_type_q == t_rd_q);
    if (m_left && (!have || c_label[MAX_ROWS-1] < cand)) begin
      cand = c_label[MAX_ROWS-1];
      have = 1'b1;
    end
    if (m_up && (!have || prev_label_q < cand)) begin
      cand = prev_label_q;
      have = 1'b1;
    end
    take_new    = !have;
    new_label   = have ? cand : next_q[LW-1:0];
    new_valid   = s1_inb_q;
    lab_changed = (pass_q != PASS_FIRST) && (new_label != l_rd_q);

    start_pass  = ((state_q == ST_IDLE) && accept && (in_item_i.opcode == OP_LABEL)) ||
                  (pass_done && (state_d == ST_PASS));
    chain_clr   = start_pass;
    chain_shift = (state_q == ST_PASS) && s1_valid_q;

    t_raddr = cell_addr(32'(x_q), 32'(y_q));
    l_raddr = (state_q == ST_IDLE) ? cell_addr(32'(in_item_i.col), 32'(in_item_i.row))
                                   : cell_addr(32'(x_q), 32'(y_q));
    s_raddr = AW'(l_rd_q);

    t_we    = (state_q == ST_IDLE) && accept && (in_item_i.opcode == OP_WRITE) && !outside;
    t_waddr = cell_addr(32'(in_item_i.col), 32'(in_item_i.row));
    t_wdata = TYPE_BITS'(in_item_i.cell_type);

    l_we    = (state_q == ST_CLEAR) || (chain_shift && s1_inb_q);
    l_waddr = (state_q == ST_CLEAR) ? cnt_q : s1_addr_q;
    l_wdata = (state_q == ST_CLEAR) ? '0 : new_label;

    s_we    = (state_q == ST_CLEAR) || (state_q == ST_SCLR) || (state_q == ST_CNT_WR);
    s_waddr = (state_q == ST_CNT_WR) ? AW'(lab_hold_q) : cnt_q;
    s_wdata = (state_q == ST_CNT_WR) ? CW'(s_rd_q + CW'(1)) : '0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      pass_q       <= PASS_FIRST;
      issue_q      <= 1'b0;
      s1_valid_q   <= 1'b0;
      prev_valid_q <= 1'b0;
      issued_q     <= '0;
      next_q       <= '0;
      changed_q    <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;

      // Clear sweeps
      if ((state_q == ST_CLEAR) || (state_q == ST_SCLR)) begin
        cnt_q <= clr_last ? '0 : cnt_q + AW'(1);
      end

      // Issue stage: walk cells in raster order, backward for reverse passes
      s1_valid_q <= (state_q == ST_PASS) && issue_q;
      if (start_pass) begin
        issue_q <= 1'b1;
        if (pass_d == PASS_BWD) begin
          x_q <= wm1;
          y_q <= YW'(MAX_ROWS - 1);
        end else begin
          x_q <= '0;
          y_q <= '0;
        end
      end else if ((state_q == ST_PASS) && issue_q) begin
        if (last_issue) begin
          issue_q <= 1'b0;
        end else if (fwd_dir) begin
          if (y_q == YW'(MAX_ROWS - 1)) begin
            y_q <= '0;
            x_q <= x_q + XW'(1);
          end else begin
            y_q <= y_q + YW'(1);
          end
        end else begin
          if (y_q == '0) begin
            y_q <= YW'(MAX_ROWS - 1);
            x_q <= x_q - XW'(1);
          end else begin
            y_q <= y_q - YW'(1);
          end
        end
      end else if ((state_q == ST_SCLR) && clr_last) begin
        x_q <= '0;
        y_q <= '0;
      end else if ((state_q == ST_CNT_WR) && !cnt_last) begin
        if (y_q == hm1) begin
          y_q <= '0;
          x_q <= x_q + XW'(1);
        end else begin
          y_q <= y_q + YW'(1);
        end
      end

      // Merge stage bookkeeping
      if (start_pass) begin
        prev_valid_q <= 1'b0;
      end else if (chain_shift) begin
        prev_valid_q <= s1_inb_q;
      end

      if ((state_q == ST_IDLE) && start_pass) begin
        next_q <= '0;
      end else if (chain_shift && s1_inb_q && (pass_q == PASS_FIRST) && take_new) begin
        next_q <= next_q + CW'(1);
      end

      if (pass_done && (pass_q == PASS_FIRST)) begin
        issued_q <= next_q;
      end

      // Track label changes across one forward and one backward pass
      if (start_pass && (pass_d == PASS_FWD)) begin
        changed_q <= 1'b0;
      end else if (chain_shift && s1_inb_q && lab_changed) begin
        changed_q <= 1'b1;
      end

      // Output register: hold until taken
      if ((state_q == ST_IDLE && accept && in_item_i.opcode != OP_LABEL &&
           !(in_item_i.opcode == OP_READ && !outside)) ||
          (state_q == ST_RD_OUT) ||
          (state_q == ST_CNT_WR && cnt_last)) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_inb_q  <= 32'(y_q) < 32'(h_eff);
    s1_edge_q <= fwd_dir ? (y_q == '0) : (y_q == YW'(MAX_ROWS - 1));
    s1_addr_q <= cell_addr(32'(x_q), 32'(y_q));
    if (chain_shift) begin
      prev_type_q  <= t_rd_q;
      prev_label_q <= new_label;
    end
    if ((state_q == ST_RD_SIZE) || (state_q == ST_CNT_SIZE)) begin
      lab_hold_q <= l_rd_q;
    end
    if (state_q == ST_IDLE && accept) begin
      out_q.status       <= (in_item_i.opcode == OP_WRITE || in_item_i.opcode == OP_READ)
                            && outside;
      out_q.region_label <= '0;
      out_q.region_size  <= '0;
      out_q.label_total  <= 9'(issued_q);
    end else if (state_q == ST_RD_OUT) begin
      out_q.status       <= 1'b0;
      out_q.region_label <= 8'(lab_hold_q);
      out_q.region_size  <= 9'(s_rd_q);
      out_q.label_total  <= 9'(issued_q);
    end else if (state_q == ST_CNT_WR && cnt_last) begin
      out_q.status       <= 1'b0;
      out_q.region_label <= '0;
      out_q.region_size  <= '0;
      out_q.label_total  <= 9'(issued_q);
    end
  end

endmodule

FILE: test/gccl_checker.sv
// Checker for the grid connected component labeler: watches the item and
// configuration channels, predicts every result and compares it.
// Depends on gccl_pkg.
`timescale 1ns / 1ps

module gccl_checker
  import gccl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_item_t         in_item_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_item_t        out_item_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic             cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int               pending_o,
  output int               errors_o
);

  localparam int NCOLS  = MAX_COLS_DEF;
  localparam int NROWS  = MAX_ROWS_DEF;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int NO_LABEL = 1 << 20;

  logic [2:0]       type_mem [NCELLS];
  int               label_mem[NCELLS];
  int               size_mem [NCELLS];
  int               labels_issued;
  logic [CFG_W-1:0] width_reg, height_reg;
  out_item_t        expected_q[$];

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int max);
    if (v == 0) return 1;
    if (int'(v) > max) return max;
    return int'(v);
  endfunction

  function automatic int lower_match(int best, int n, logic [2:0] t);
    if (type_mem[n] == t && label_mem[n] < best) return label_mem[n];
    return best;
  endfunction

  // First raster pass, then min passes over four neighbors until stable.
  function automatic void label_regions();
    int w, h, nxt, i, best;
    bit changed;
    logic [2:0] t;
    w = clamp_dim(width_reg, NCOLS);
    h = clamp_dim(height_reg, NROWS);
    nxt = 0;
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        i = x * NROWS + y;
        t = type_mem[i];
        best = NO_LABEL;
        if (x > 0) best = lower_match(best, i - NROWS, t);
        if (y > 0) best = lower_match(best, i - 1, t);
        if (best == NO_LABEL) best = nxt++;
        label_mem[i] = best;
      end
    end
    labels_issued = nxt;
    do begin
      changed = 0;
      for (int k = 0; k < NCELLS; k++) size_mem[k] = 0;
      for (int x = 0; x < w; x++) begin
        for (int y = 0; y < h; y++) begin
          i = x * NROWS + y;
          t = type_mem[i];
          best = NO_LABEL;
          if (x > 0) best = lower_match(best, i - NROWS, t);
          if (y > 0) best = lower_match(best, i - 1, t);
          if (x + 1 < w) best = lower_match(best, i + NROWS, t);
          if (y + 1 < h) best = lower_match(best, i + 1, t);
          if (best != NO_LABEL && best < label_mem[i]) begin
            label_mem[i] = best;
            changed = 1;
          end
          if (label_mem[i] < NCELLS) size_mem[label_mem[i]]++;
        end
      end
    end while (changed);
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int w, h, i;
    bit outside;
    w = clamp_dim(width_reg, NCOLS);
    h = clamp_dim(height_reg, NROWS);
    outside = (int'(it.col) >= w) || (int'(it.row) >= h);
    i = int'(it.col) * NROWS + int'(it.row);
    r = '0;
    case (it.opcode)
      OP_WRITE: begin
        if (outside) r.status = 1'b1;
        else type_mem[i] = it.cell_type;
      end
      OP_LABEL: label_regions();
      OP_READ: begin
        if (outside) r.status = 1'b1;
        else begin
          r.region_label = label_mem[i][7:0];
          if (label_mem[i] < NCELLS) r.region_size = size_mem[label_mem[i]][8:0];
        end
      end
      default: ;
    endcase
    r.label_total = labels_issued[8:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      for (int k = 0; k < NCELLS; k++) begin
        type_mem[k]  = '0;
        label_mem[k] = 0;
        size_mem[k]  = 0;
      end
      labels_issued = 0;
      width_reg     = 9;
      height_reg    = 9;
      expected_q.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      // take the result first: its expectation was queued at an earlier edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result with nothing expected: %p", $realtime, out_item_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_item_i.status !== exp_r.status ||
              out_item_i.region_label !== exp_r.region_label ||
              out_item_i.region_size !== exp_r.region_size ||
              out_item_i.label_total !== exp_r.label_total) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: status %0d/%0d label %0d/%0d size %0d/%0d total %0d/%0d",
                       $realtime, exp_r.status, out_item_i.status,
                       exp_r.region_label, out_item_i.region_label,
                       exp_r.region_size, out_item_i.region_size,
                       exp_r.label_total, out_item_i.label_total);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp_r = predict_result(in_item_i);
        expected_q = {expected_q, exp_r};
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_BOARD_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: test/tb_grid_connected_component_labeler_core.sv
// Testbench top for grid_connected_component_labeler_core: drives writes,
// label runs and reads under random gaps and stalls; gccl_checker compares.
// Depends on gccl_pkg, gccl_checker and the block.
`timescale 1ns / 1ps

module tb_grid_connected_component_labeler_core;
  import gccl_pkg::*;

  localparam int ITEM_GOAL = 1900;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = REG_BOARD_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  int               pending, errors;

  int items_sent = 0;
  int board_w = 9, board_h = 9;  // effective size, as the block clamps it
  int stall_mode = 0;
  int stall_left = 0;

  always #6 clk = ~clk;

  grid_connected_component_labeler_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  gccl_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // Receiver stall: switch at random between no stall, light and heavy
  // stalling, so stalls land on every phase of the block's work.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 2);
      default: out_stall <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    endcase
  end

  // Mostly no gap, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Hold the item until the block takes it; stall is checked at the falling
  // edge, so the item leaves at the next rising edge.
  task automatic send_item(logic [1:0] op, int col, int row, int typ, bit gaps);
    int gap;
    bit taken;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_item.opcode <= op;
    in_item.col    <= col[3:0];
    in_item.row    <= row[3:0];
    in_item.cell_type <= typ[2:0];
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    bit taken;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    if (idx == REG_BOARD_WIDTH) board_w = (value == 0) ? 1 : (value > 16 ? 16 : value);
    else board_h = (value == 0) ? 1 : (value > 16 ? 16 : value);
  endtask

  task automatic set_board(int w, int h);
    write_reg(REG_BOARD_WIDTH, w);
    write_reg(REG_BOARD_HEIGHT, h);
  endtask

  // Board sizes for the random phases: extremes, out-of-range codes, and
  // mostly small boards so label runs stay short.
  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 10) return $urandom_range(17, 31);
    if (r < 15) return 16;
    if (r < 25) return 1;
    return $urandom_range(2, 7);
  endfunction

  // Few types give large regions; sometimes use the full type range.
  function automatic int pick_type(int palette);
    return (palette == 0) ? $urandom_range(0, 7) : $urandom_range(0, palette);
  endfunction

  initial begin
    int nwrites, nreads, palette, w, h;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the whole grid so no label run ever sees a cell never written.
    set_board(16, 16);
    for (int c = 0; c < 16; c++)
      for (int r = 0; r < 16; r++)
        send_item(OP_WRITE, c, r, (c + r) % 2 == 0 ? 7 : 0, 1'b0);

    // Directed part: checkerboard on a full board gives 256 labels, then
    // reset-size board, outside coordinates, no-op opcode, stale labels.
    send_item(OP_READ, 3, 3, 0, 1'b0);            // before any label run
    send_item(OP_LABEL, 0, 0, 0, 1'b0);
    send_item(OP_READ, 0, 0, 0, 1'b0);
    send_item(OP_READ, 15, 15, 0, 1'b0);
    send_item(OP_READ, 15, 0, 0, 1'b0);
    send_item(OP_NOP, 15, 15, 7, 1'b0);           // no-op opcode
    set_board(9, 9);
    send_item(OP_WRITE, 9, 0, 5, 1'b0);           // outside: ignored
    send_item(OP_WRITE, 0, 9, 5, 1'b0);
    send_item(OP_READ, 15, 8, 0, 1'b0);
    send_item(OP_READ, 8, 15, 0, 1'b0);
    send_item(OP_WRITE, 4, 4, 7, 1'b0);
    send_item(OP_READ, 4, 4, 0, 1'b0);            // stale label
    send_item(OP_LABEL, 0, 0, 0, 1'b0);
    send_item(OP_READ, 4, 4, 0, 1'b0);
    set_board(0, 31);                             // acts as 1 by 16
    send_item(OP_LABEL, 0, 0, 0, 1'b0);
    send_item(OP_READ, 0, 15, 0, 1'b0);
    send_item(OP_READ, 1, 0, 0, 1'b0);
    set_board(31, 0);                             // acts as 16 by 1
    send_item(OP_LABEL, 0, 0, 0, 1'b0);
    send_item(OP_READ, 15, 0, 0, 1'b0);

    // Random phases: a board size, a burst of writes with random content,
    // a label run, then reads, with some noise mixed in.
    while (items_sent < ITEM_GOAL) begin
      set_board(pick_dim(), pick_dim());
      w = board_w;
      h = board_h;
      palette = $urandom_range(0, 3);
      nwrites = $urandom_range(4, 30);
      for (int k = 0; k < nwrites; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 7), 1'b1);
        else
          send_item(OP_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                    pick_type(palette), 1'b1);
      end
      if ($urandom_range(0, 7) == 0) drain();
      send_item(OP_LABEL, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 7), 1'b1);
      nreads = $urandom_range(6, 24);
      for (int k = 0; k < nreads; k++) begin
        case ($urandom_range(0, 19))
          0:       send_item(OP_NOP, $urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 7), 1'b1);
          1, 2:    send_item(OP_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 7), 1'b1);
          3:       send_item(OP_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                             pick_type(palette), 1'b1);
          default: send_item(OP_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                             $urandom_range(0, 7), 1'b1);
        endcase
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/gccl_pkg.sv
rtl/core/gccl_cell.sv
rtl/core/grid_connected_component_labeler_core.sv
test/gccl_checker.sv
test/tb_grid_connected_component_labeler_core.sv
